[rtl/core/btgl_pkg.sv]
// ----------------------------------------------------------------------------
// btgl_pkg
// Shared types and constants of the bitmap text glyph layout block.
// ----------------------------------------------------------------------------
package btgl_pkg;

  localparam int LINE_CHARS = 32;
  localparam int LEN_W      = $clog2(LINE_CHARS + 1);
  localparam int IDX_W      = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

  localparam int CODE_W = 8;
  localparam int CELL_W = 7;
  localparam int POS_W  = 16;
  localparam int SRC_W  = 10;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CODE_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [CODE_W-1:0] HIGH_FOLD    = 8'd127;
  localparam logic [CODE_W-1:0] HIGH_DROP    = 8'd32;
  localparam logic [POS_W-1:0]  LINE_GAP     = 16'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FIRST_CODE  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_LAST_CODE   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_CELL_WIDTH  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CELL_HEIGHT = 3'd3;
  localparam logic [CIDX_W-1:0] REG_ALIGN_MODE  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_ORIGIN_X    = 3'd5;
  localparam logic [CIDX_W-1:0] REG_ORIGIN_Y    = 3'd6;

  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] first_code;
    logic [CODE_W-1:0] last_code;
    logic [CELL_W-1:0] cell_width;
    logic [CELL_W-1:0] cell_height;
    logic [1:0]        align_mode;
    logic [POS_W-1:0]  origin_x;
    logic [POS_W-1:0]  origin_y;
  } cfg_t;

  typedef struct packed {
    logic             printable;
    logic [SRC_W-1:0] glyph_x;
    logic [SRC_W-1:0] glyph_y;
  } glyph_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_EVAL,
    S_DRAIN
  } state_t;

endpackage

[rtl/core/btgl_line_ram.sv]
// ----------------------------------------------------------------------------
// btgl_line_ram
// Line buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module btgl_line_ram (
  input  logic                                clk,
  input  logic                                we,
  input  logic [btgl_pkg::IDX_W-1:0]          waddr,
  input  logic [btgl_pkg::CODE_W-1:0]         wdata,
  input  logic                                re,
  input  logic [btgl_pkg::IDX_W-1:0]          raddr,
  output logic [btgl_pkg::CODE_W-1:0]         rdata
);
  import btgl_pkg::*;

  logic [CODE_W-1:0] mem [LINE_CHARS];
  logic [CODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/btgl_glyph_map.sv]
// ----------------------------------------------------------------------------
// btgl_glyph_map
// Maps a stored character code to its printable flag and font sheet position.
// ----------------------------------------------------------------------------
module btgl_glyph_map (
  input  logic [btgl_pkg::CODE_W-1:0] code,
  input  btgl_pkg::cfg_t              cfg,
  output btgl_pkg::glyph_t            glyph
);
  import btgl_pkg::*;

  logic [CODE_W-1:0]       folded;
  logic [CODE_W-1:0]       idx;
  logic [CELL_W+3:0]       gx_full;
  logic [CELL_W+3:0]       gy_full;

  always_comb begin
    folded = (code > HIGH_FOLD) ? code - HIGH_DROP : code;
    idx    = folded - cfg.first_code;
    // sheet has 16 columns: low nibble is the column, high nibble the row
    gx_full = (CELL_W+4)'(idx[3:0]) * (CELL_W+4)'(cfg.cell_width);
    gy_full = (CELL_W+4)'(idx[7:4]) * (CELL_W+4)'(cfg.cell_height);
    glyph.printable = (folded != SPACE_CODE) && (folded >= cfg.first_code) &&
                      (folded <= cfg.last_code);
    glyph.glyph_x = gx_full[SRC_W-1:0];
    glyph.glyph_y = gy_full[SRC_W-1:0];
  end

endmodule

[rtl/core/bitmap_text_glyph_layout.sv]
// ----------------------------------------------------------------------------
// bitmap_text_glyph_layout
// Buffers text one line at a time and emits glyph blit requests on flush.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | request   | tdata[7:0] char_code, tlast text_end
//  out_    | result    | tdata glyph_x, glyph_y, dest_x, dest_y; tlast run_last
//  cfg_    | write     | cfg_index selects register, cfg_data value
//
//  A character that causes no flush leaves the block ready for the next one.
//  A flush takes the accept step, a setup step, then per stored character a
//  line buffer read and an evaluate step, and a drain step; an empty line
//  skips the walk and the drain.
//  A full output register stalls the walk at the evaluate and drain steps.
//  Synchronous reset clears control state; the line buffer needs no clearing.
// ----------------------------------------------------------------------------
module bitmap_text_glyph_layout (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [7:0]                             in_tdata,   // [7:0] char_code
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [9:0] glyph_x, [19:10] glyph_y, [35:20] dest_x, [51:36] dest_y, zero pad
  output logic [btgl_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast,
  input  logic                                   cfg_we,
  input  logic [btgl_pkg::CIDX_W-1:0]            cfg_index,
  input  logic [btgl_pkg::CFG_W-1:0]             cfg_data
);
  import btgl_pkg::*;

  state_t state_r, state_nxt;
  cfg_t   cfg_r;

  logic [LEN_W-1:0]  line_len_r;
  logic [LEN_W-1:0]  flen_r;
  logic [LEN_W-1:0]  pos_r;
  logic [POS_W-1:0]  offset_r;
  logic [POS_W-1:0]  dy_r;
  logic [POS_W-1:0]  x_r;

  logic              pend_v_r;
  logic [SRC_W-1:0]  pend_gx_r;
  logic [SRC_W-1:0]  pend_gy_r;
  logic [POS_W-1:0]  pend_dx_r;

  logic              out_valid_r;
  logic              out_last_r;
  logic [SRC_W-1:0]  out_gx_r;
  logic [SRC_W-1:0]  out_gy_r;
  logic [POS_W-1:0]  out_dx_r;
  logic [POS_W-1:0]  out_dy_r;

  logic              in_acc;
  logic              is_nl;
  logic              do_store;
  logic              flush_req;
  logic [LEN_W-1:0]  flen;
  logic              slot_free;
  logic              last_pos;
  logic [LEN_W+CELL_W-1:0] width;
  logic [POS_W-1:0]  sub;

  logic              ram_re;
  logic [CODE_W-1:0] ram_rdata;
  glyph_t            glyph;

  logic              in_ready;
  logic              advance;
  logic              load_pend;
  logic              push;
  logic              push_last;

  btgl_line_ram u_ram (
    .clk   (clk),
    .we    (in_acc && do_store),
    .waddr (line_len_r[IDX_W-1:0]),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (pos_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  btgl_glyph_map u_map (
    .code  (ram_rdata),
    .cfg   (cfg_r),
    .glyph (glyph)
  );

  always_comb begin
    in_acc    = in_tvalid && in_ready;
    is_nl     = (in_tdata == NEWLINE_CODE);
    do_store  = !is_nl && (line_len_r < LEN_W'(LINE_CHARS));
    flen      = do_store ? line_len_r + LEN_W'(1) : line_len_r;
    flush_req = is_nl || in_tlast;
    slot_free = !out_valid_r || out_tready;
    last_pos  = ((pos_r + LEN_W'(1)) == flen_r);
    width     = (LEN_W+CELL_W)'(flen_r) * (LEN_W+CELL_W)'(cfg_r.cell_width);
    case (cfg_r.align_mode)
      ALIGN_CENTER: sub = POS_W'(width >> 1);
      ALIGN_RIGHT:  sub = POS_W'(width);
      default:      sub = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    advance   = 1'b0;
    load_pend = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_tvalid && flush_req) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        state_nxt = (flen_r == '0) ? S_IDLE : S_READ;
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // a new glyph displaces the pending one, which needs a free slot
        if (!(glyph.printable && pend_v_r && !slot_free)) begin
          advance   = 1'b1;
          load_pend = glyph.printable;
          push      = glyph.printable && pend_v_r;
          state_nxt = last_pos ? S_DRAIN : S_READ;
        end
      end
      S_DRAIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_code  <= 8'd32;
      cfg_r.last_code   <= 8'd127;
      cfg_r.cell_width  <= 7'd8;
      cfg_r.cell_height <= 7'd16;
      cfg_r.align_mode  <= ALIGN_LEFT;
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_CODE:  cfg_r.first_code  <= cfg_data[CODE_W-1:0];
        REG_LAST_CODE:   cfg_r.last_code   <= cfg_data[CODE_W-1:0];
        REG_CELL_WIDTH:  cfg_r.cell_width  <= cfg_data[CELL_W-1:0];
        REG_CELL_HEIGHT: cfg_r.cell_height <= cfg_data[CELL_W-1:0];
        REG_ALIGN_MODE:  cfg_r.align_mode  <= cfg_data[1:0];
        REG_ORIGIN_X:    cfg_r.origin_x    <= cfg_data;
        REG_ORIGIN_Y:    cfg_r.origin_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // line state and walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
      offset_r   <= '0;
      pend_v_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        line_len_r <= flush_req ? '0 : flen;
        if (in_tlast) begin
          offset_r <= '0;
        end else if (is_nl) begin
          offset_r <= offset_r + POS_W'(cfg_r.cell_height) + LINE_GAP;
        end
      end
      if (load_pend) begin
        pend_v_r <= 1'b1;
      end else if (push_last) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      flen_r <= flen;
      dy_r   <= cfg_r.origin_y + offset_r;
    end
    if (state_r == S_SETUP) begin
      x_r   <= cfg_r.origin_x - sub;
      pos_r <= '0;
    end else if (advance) begin
      x_r   <= x_r + POS_W'(cfg_r.cell_width);
      pos_r <= pos_r + LEN_W'(1);
    end
    if (load_pend) begin
      pend_gx_r <= glyph.glyph_x;
      pend_gy_r <= glyph.glyph_y;
      pend_dx_r <= x_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_gx_r   <= pend_gx_r;
      out_gy_r   <= pend_gy_r;
      out_dx_r   <= pend_dx_r;
      out_dy_r   <= dy_r;
      out_last_r <= push_last;
    end
  end

  assign in_tready  = in_ready;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - 2*SRC_W - 2*POS_W)'(0),
                       out_dy_r, out_dx_r, out_gy_r, out_gx_r};

endmodule

[rtl/core/btgl_checker.sv]
// ----------------------------------------------------------------------------
// btgl_checker
// Port-level checks of the bitmap text glyph layout block.
// ----------------------------------------------------------------------------
module btgl_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [7:0]                          in_tdata,
  input logic                                in_tlast,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [btgl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                                out_tlast
);
  import btgl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result dropped or changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the output side");

  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tlast || in_tdata == NEWLINE_CODE) |=> !in_tready)
    else $error("flush did not hold off the next request");

  a_store_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && in_tdata != NEWLINE_CODE |=> in_tready)
    else $error("plain character did not return to ready");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && in_tdata != NEWLINE_CODE && !out_tvalid
    |=> !out_tvalid)
    else $error("result appeared without a flush");

endmodule

bind bitmap_text_glyph_layout btgl_checker u_btgl_checker (.*);
